>>> sv/opm_pkg.sv
`timescale 1ns / 1ps
package opm_pkg;

  // Field widths of the job record, sized for the largest frame and window
  localparam int COL_W  = 12;
  localparam int SLOT_W = 5;

  // Level = floor(x / 765) by reciprocal: q0 = (x * LVL_K) >> LVL_SHIFT, then one correction
  localparam int          LVL_SHIFT = 26;
  localparam logic [16:0] LVL_K     = 17'd87724;
  localparam logic [17:0] LVL_DIV   = 18'd765;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;
  localparam logic [1:0] CFG_GAIN   = 2'd3;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [9:0] out_col;
    logic [9:0] out_row;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } out_t;

  // One window to filter, handed from the front to the back
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic [9:0]        out_col;
    logic [9:0]        out_row;
    logic              last;
  } job_t;

endpackage

>>> sv/opm_ram.sv
`timescale 1ns / 1ps
module opm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/opm_job_q.sv
`timescale 1ns / 1ps
module opm_job_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  opm_pkg::job_t push_data,
  input  logic          pop,
  output opm_pkg::job_t head,
  output logic          q_empty,
  output logic          q_full
);
  import opm_pkg::*;

  job_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign head    = mem_r[rp_r];
  assign q_empty = (cnt_r == 2'd0);
  assign q_full  = (cnt_r == 2'd2);

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

>>> sv/opm_front.sv
`timescale 1ns / 1ps
module opm_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           accept,
  input  opm_pkg::in_t                                   pix,
  input  logic [$clog2(MAX_WIDTH):0]                     width_eff,
  input  logic [$clog2(MAX_HEIGHT):0]                    height_eff,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]                rad_eff,
  output logic                                           ls_we,
  output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0]  ls_waddr,
  output logic [23:0]                                    ls_wdata,
  output logic                                           job_push,
  output opm_pkg::job_t                                  job_data,
  output logic                                           row_start
);
  import opm_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = $clog2(MAX_HEIGHT);
  localparam int STORE = 2*MAX_RADIUS+1;
  localparam int SLW   = $clog2(STORE);
  localparam int ADRW  = $clog2(STORE*MAX_WIDTH);
  localparam int CMPW  = 14;

  logic [CW-1:0]  col_r, col_nxt;
  logic [HW-1:0]  row_r, row_nxt;
  logic [SLW-1:0] slot_r, slot_nxt;

  logic [CW-1:0]   c;
  logic [HW:0]     r1;
  logic [HW-1:0]   r;
  logic [SLW-1:0]  s1, s;
  logic [CMPW-1:0] two_r;
  logic [CMPW-1:0] c_inc, r_inc;
  logic            emit;

  function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] v);
    return (v == SLW'(STORE-1)) ? '0 : v + SLW'(1);
  endfunction

  // Place the incoming pixel, folding a stale position back into the frame
  always_comb begin
    if (CMPW'(col_r) >= CMPW'(width_eff)) begin
      c  = '0;
      r1 = (HW+1)'(row_r) + (HW+1)'(1);
      s1 = slot_inc(slot_r);
    end else begin
      c  = col_r;
      r1 = (HW+1)'(row_r);
      s1 = slot_r;
    end
    if (CMPW'(r1) >= CMPW'(height_eff)) begin
      r = '0;
      s = '0;
    end else begin
      r = r1[HW-1:0];
      s = s1;
    end
  end

  assign two_r = CMPW'({rad_eff, 1'b0});
  assign emit  = (CMPW'(c) >= two_r) && (CMPW'(r) >= two_r);
  assign c_inc = CMPW'(c) + CMPW'(1);
  assign r_inc = CMPW'(r) + CMPW'(1);

  // Step the raster position
  always_comb begin
    col_nxt  = c_inc[CW-1:0];
    row_nxt  = r;
    slot_nxt = s;
    if (c_inc >= CMPW'(width_eff)) begin
      col_nxt  = '0;
      row_nxt  = r_inc[HW-1:0];
      slot_nxt = slot_inc(s);
      if (r_inc >= CMPW'(height_eff)) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  // Write the pixel into its line and hand complete windows to the back
  assign ls_we    = accept;
  assign ls_waddr = ADRW'(s) * ADRW'(MAX_WIDTH) + ADRW'(c);
  assign ls_wdata = {pix.red_in, pix.green_in, pix.blue_in};
  assign job_push = accept && emit;

  always_comb begin
    job_data.col     = COL_W'(c);
    job_data.slot    = SLOT_W'(s);
    job_data.out_col = 10'(CMPW'(c) - CMPW'(rad_eff));
    job_data.out_row = 10'(CMPW'(r) - CMPW'(rad_eff));
    job_data.last    = (CMPW'(c) == CMPW'(width_eff) - CMPW'(1))
                    && (CMPW'(r) == CMPW'(height_eff) - CMPW'(1));
  end

  assign row_start = (col_r == '0);

endmodule

>>> sv/opm_back.sv
`timescale 1ns / 1ps
module opm_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7,
  parameter int LEVELS     = 256
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]                rad_eff,
  input  logic [7:0]                                     gain,
  input  opm_pkg::job_t                                  job,
  input  logic                                           job_avail,
  output logic                                           job_pop,
  output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0]  ls_raddr,
  input  logic [23:0]                                    ls_rdata,
  output logic                                           out_valid,
  output opm_pkg::out_t                                  out_data,
  input  logic                                           out_pop,
  output logic                                           busy
);
  import opm_pkg::*;

  localparam int STORE = 2*MAX_RADIUS+1;
  localparam int ADRW  = $clog2(STORE*MAX_WIDTH);
  localparam int SIDEW = $clog2(STORE+1);
  localparam int LW    = $clog2(LEVELS);
  localparam int CNTW  = $clog2(STORE*STORE+1);
  localparam int SUMW  = CNTW + 8;
  localparam int BINW  = CNTW + 3*SUMW;
  localparam int DW    = SUMW + 8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_DRAIN, ST_DIV, ST_HOLD
  } state_t;

  state_t            state_r;
  job_t              job_r;
  logic [SIDEW-1:0]  dx_r, dy_r;
  logic [SLOT_W-1:0] slot_r;
  logic [COL_W-1:0]  colstart_r;
  logic [2:0]        div_i_r;
  logic [SUMW-1:0]   rem_r [3];
  logic [7:0]        quo_r [3];
  logic              out_valid_r;
  out_t              out_r;

  logic [SIDEW-1:0]  side_m1;
  logic [SLOT_W-1:0] two_r, top_slot;
  logic              start_win;
  logic              pipe_idle;

  // Level pipeline and accumulator
  logic              v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [23:0]       rgb2_r, rgb3_r, rgb4_r;
  logic [17:0]       x2_r, x3_r;
  logic [8:0]        q0_r;
  logic [LW-1:0]     lvl4_r, lvl5_r;
  logic [BINW-1:0]   bin5_r;
  logic [LEVELS-1:0] bin_vld_r;
  logic [CNTW-1:0]   best_cnt_r;
  logic [LW-1:0]     best_lvl_r;
  logic [SUMW-1:0]   best_sum_r [3];

  logic [9:0]        csum;
  logic [34:0]       prod;
  logic [17:0]       rem_lvl;
  logic [8:0]        q_fix;
  logic [LW-1:0]     lvl3;
  logic [BINW-1:0]   bin_rdata, cur, upd;
  logic [CNTW-1:0]   new_cnt;
  logic [SUMW-1:0]   new_sum [3];
  logic              take_best;

  assign side_m1   = SIDEW'({rad_eff, 1'b0});
  assign two_r     = SLOT_W'({rad_eff, 1'b0});
  assign top_slot  = (job.slot >= two_r) ? job.slot - two_r
                                         : job.slot + SLOT_W'(STORE) - two_r;
  assign start_win = (state_r == ST_IDLE) && job_avail;
  assign pipe_idle = !v1_r && !v2_r && !v3_r && !v4_r;
  assign job_pop   = start_win;
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign ls_raddr = ADRW'(slot_r) * ADRW'(MAX_WIDTH) + ADRW'(colstart_r) + ADRW'(dx_r);

  // Sequence one window: read it, drain, divide, deliver
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
    end else begin
      v1_r <= 1'b0;
      if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (job_avail) begin
            job_r      <= job;
            colstart_r <= job.col - COL_W'({rad_eff, 1'b0});
            slot_r     <= top_slot;
            dx_r       <= '0;
            dy_r       <= '0;
            state_r    <= ST_RUN;
          end
        end
        ST_RUN: begin
          v1_r <= 1'b1;
          if (dx_r == side_m1) begin
            dx_r   <= '0;
            dy_r   <= dy_r + SIDEW'(1);
            slot_r <= (slot_r == SLOT_W'(STORE-1)) ? '0 : slot_r + SLOT_W'(1);
            if (dy_r == side_m1) state_r <= ST_DRAIN;
          end else begin
            dx_r <= dx_r + SIDEW'(1);
          end
        end
        ST_DRAIN: begin
          if (pipe_idle) begin
            for (int k = 0; k < 3; k++) begin
              rem_r[k] <= best_sum_r[k];
              quo_r[k] <= '0;
            end
            div_i_r <= 3'd7;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          // One quotient bit per lane each cycle
          for (int k = 0; k < 3; k++) begin
            if (DW'(rem_r[k]) >= (DW'(best_cnt_r) << div_i_r)) begin
              rem_r[k]          <= SUMW'(DW'(rem_r[k]) - (DW'(best_cnt_r) << div_i_r));
              quo_r[k][div_i_r] <= 1'b1;
            end
          end
          div_i_r <= div_i_r - 3'd1;
          if (div_i_r == 3'd0) state_r <= ST_HOLD;
        end
        ST_HOLD: begin
          if (!out_valid_r) begin
            out_r.out_col    <= job_r.out_col;
            out_r.out_row    <= job_r.out_row;
            out_r.red_out    <= quo_r[0];
            out_r.green_out  <= quo_r[1];
            out_r.blue_out   <= quo_r[2];
            out_r.frame_last <= job_r.last;
            out_valid_r      <= 1'b1;
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Level arithmetic
  assign csum    = 10'(ls_rdata[23:16]) + 10'(ls_rdata[15:8]) + 10'(ls_rdata[7:0]);
  assign prod    = 35'(x2_r) * 35'(LVL_K);
  assign rem_lvl = x3_r - 18'(18'(q0_r) * LVL_DIV);
  assign q_fix   = q0_r + ((rem_lvl >= LVL_DIV) ? 9'd1 : 9'd0);
  assign lvl3    = (q_fix > 9'(LEVELS-1)) ? LW'(LEVELS-1) : LW'(q_fix);

  opm_ram #(.WIDTH(BINW), .DEPTH(LEVELS)) u_bins (
    .clk   (clk),
    .we    (v4_r),
    .waddr (lvl4_r),
    .wdata (upd),
    .raddr (lvl3),
    .rdata (bin_rdata)
  );

  // Merge the pixel into its bin, forwarding the bin written just before
  always_comb begin
    if (v5_r && lvl5_r == lvl4_r)  cur = bin5_r;
    else if (bin_vld_r[lvl4_r])   cur = bin_rdata;
    else                          cur = '0;
    new_cnt    = cur[BINW-1 -: CNTW] + CNTW'(1);
    new_sum[0] = cur[3*SUMW-1 -: SUMW] + SUMW'(rgb4_r[23:16]);
    new_sum[1] = cur[2*SUMW-1 -: SUMW] + SUMW'(rgb4_r[15:8]);
    new_sum[2] = cur[SUMW-1:0]         + SUMW'(rgb4_r[7:0]);
    upd        = {new_cnt, new_sum[0], new_sum[1], new_sum[2]};
    take_best  = (new_cnt > best_cnt_r) || (new_cnt == best_cnt_r && lvl4_r < best_lvl_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      v5_r       <= 1'b0;
      bin_vld_r  <= '0;
      best_cnt_r <= '0;
      best_lvl_r <= '0;
    end else begin
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      if (start_win) begin
        bin_vld_r  <= '0;
        best_cnt_r <= '0;
        best_lvl_r <= '0;
      end else if (v4_r) begin
        bin_vld_r[lvl4_r] <= 1'b1;
        if (take_best) begin
          best_cnt_r <= new_cnt;
          best_lvl_r <= lvl4_r;
        end
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    x2_r   <= 18'(csum) * 18'(gain);
    rgb2_r <= ls_rdata;
    q0_r   <= prod[LVL_SHIFT+8:LVL_SHIFT];
    x3_r   <= x2_r;
    rgb3_r <= rgb2_r;
    lvl4_r <= lvl3;
    rgb4_r <= rgb3_r;
    lvl5_r <= lvl4_r;
    bin5_r <= upd;
    if (v4_r && take_best) begin
      for (int k = 0; k < 3; k++) best_sum_r[k] <= new_sum[k];
    end
  end

endmodule

>>> sv/oil_paint_mode_filter.sv
`timescale 1ns / 1ps
// Oil-paint mode filter. Pixels enter in raster order, one per push, and are kept in a
// line store of 2*MAX_RADIUS+1 rows. Each pixel that completes a (2R+1)-square window
// yields one result for the window center: the truncated mean color of the most common
// brightness level (lowest level on a tie); border pixels yield nothing. A pixel that
// completes no window is accepted whenever in_full is low. A pixel that completes one is
// queued (two deep) for the window engine, which reads one window pixel per cycle from
// the line-store port, then drains, divides with an 8-step divider and delivers, one
// window at a time. At the start of each row the input holds full until all queued
// windows are done. Configuration is taken every cycle but must be written only while
// idle.
module oil_paint_mode_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 7,
  parameter int LEVELS     = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  opm_pkg::in_t  in_data,
  output logic          out_empty,
  input  logic          out_pop,
  output opm_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [10:0]   cfg_data
);
  import opm_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = $clog2(MAX_HEIGHT);
  localparam int RW    = $clog2(MAX_RADIUS+1);
  localparam int STORE = 2*MAX_RADIUS+1;
  localparam int ADRW  = $clog2(STORE*MAX_WIDTH);

  logic [10:0] width_r, height_r;
  logic [2:0]  radius_r;
  logic [7:0]  gain_r;

  logic [CW:0]     width_eff;
  logic [HW:0]     height_eff;
  logic [RW-1:0]   rad_eff;
  logic            accept;
  logic            ls_we;
  logic [ADRW-1:0] ls_waddr, ls_raddr;
  logic [23:0]     ls_wdata, ls_rdata;
  logic            job_push, job_pop, q_empty, q_full, row_start, back_busy;
  logic            out_valid;
  job_t            job_in, job_head;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 11'd1024;
      radius_r <= 3'd2;
      gain_r   <= 8'd20;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_RADIUS: radius_r <= cfg_data[2:0];
        CFG_GAIN:   gain_r   <= cfg_data[7:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  // Clamp sizes and radius into the supported range
  always_comb begin
    if (width_r == 11'd0)                 width_eff = (CW+1)'(1);
    else if (14'(width_r) > 14'(MAX_WIDTH)) width_eff = (CW+1)'(MAX_WIDTH);
    else                                  width_eff = (CW+1)'(width_r);
    if (height_r == 11'd0)                  height_eff = (HW+1)'(1);
    else if (14'(height_r) > 14'(MAX_HEIGHT)) height_eff = (HW+1)'(MAX_HEIGHT);
    else                                    height_eff = (HW+1)'(height_r);
    if (5'(radius_r) > 5'(MAX_RADIUS)) rad_eff = RW'(MAX_RADIUS);
    else                               rad_eff = RW'(radius_r);
  end

  // Hold off input while the job queue is full, and a new row while windows of the current one are still read
  assign in_full = q_full || ((!q_empty || back_busy) && row_start);
  assign accept  = in_push && !in_full;

  opm_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .pix       (in_data),
    .width_eff (width_eff),
    .height_eff(height_eff),
    .rad_eff   (rad_eff),
    .ls_we     (ls_we),
    .ls_waddr  (ls_waddr),
    .ls_wdata  (ls_wdata),
    .job_push  (job_push),
    .job_data  (job_in),
    .row_start (row_start)
  );

  opm_ram #(.WIDTH(24), .DEPTH(STORE*MAX_WIDTH)) u_lines (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (ls_wdata),
    .raddr (ls_raddr),
    .rdata (ls_rdata)
  );

  opm_job_q u_jobs (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_data(job_in),
    .pop      (job_pop),
    .head     (job_head),
    .q_empty  (q_empty),
    .q_full   (q_full)
  );

  opm_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS),
    .LEVELS    (LEVELS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rad_eff  (rad_eff),
    .gain     (gain_r),
    .job      (job_head),
    .job_avail(!q_empty),
    .job_pop  (job_pop),
    .ls_raddr (ls_raddr),
    .ls_rdata (ls_rdata),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_pop  (out_pop),
    .busy     (back_busy)
  );

  assign out_empty = !out_valid;

`ifndef SYNTHESIS
  a_job_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !q_full || job_pop)
    else $error("job queue overflow");

  a_job_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !q_empty)
    else $error("job taken from empty queue");

  a_no_new_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && row_start) |-> (q_empty && !back_busy))
    else $error("new row started while windows pending");
`endif

endmodule

>>> tb/sv/tb_oil_paint_mode_filter.sv
`timescale 1ns / 1ps
module tb_oil_paint_mode_filter;
  import opm_pkg::*;

  localparam int  STORE_ROWS    = 15;
  localparam int  FRAME_MAX     = 1024;
  localparam int  SETTLE_CYCLES = 600;
  localparam int  CYCLE_LIMIT   = 1000000;
  localparam int  RANDOM_PIXELS = 140;

  typedef enum logic [1:0] {STEP_PIXEL, STEP_CONFIG, STEP_SETTLE} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [1:0]  idx;
    logic [10:0] val;
    in_t         pix;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  in_t         in_data = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_WIDTH;
  logic [10:0] cfg_data = '0;

  step_t       pending[$];
  out_t        filtered_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          push_gap = 0;
  int          pop_gap = 0;
  int          settle_cnt = 0;
  logic        calm;

  // Filter state mirrored from the block
  logic [23:0] pix_rows[STORE_ROWS*FRAME_MAX];
  logic [10:0] frame_w = 11'd1024;
  logic [10:0] frame_h = 11'd1024;
  logic [2:0]  radius = 3'd2;
  logic [7:0]  gain = 8'd20;
  int          next_col = 0;
  int          next_row = 0;

  oil_paint_mode_filter dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  assign calm = pending.size() < 120;

  // Bin the window that this pixel completes and queue the expected pixel
  task automatic filter_pixel(in_t p);
    int w, h, c, r, sd, lvl, best, bestcnt, slot, pr, pg, pb;
    int cnt[256], sr[256], sg[256], sb[256];
    out_t o;
    w = (frame_w < 1) ? 1 : (frame_w > FRAME_MAX) ? FRAME_MAX : frame_w;
    h = (frame_h < 1) ? 1 : (frame_h > FRAME_MAX) ? FRAME_MAX : frame_h;
    if (next_col >= w) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= h) next_row = 0;
    c = next_col;
    r = next_row;
    pix_rows[(r % STORE_ROWS) * FRAME_MAX + c] = p;
    sd = 2 * radius + 1;
    if (c >= 2 * radius && r >= 2 * radius) begin
      for (int i = 0; i < 256; i++) begin
        cnt[i] = 0; sr[i] = 0; sg[i] = 0; sb[i] = 0;
      end
      for (int dy = 0; dy < sd; dy++) begin
        slot = (r - 2 * radius + dy) % STORE_ROWS;
        for (int dx = 0; dx < sd; dx++) begin
          {pr, pg, pb} = {24'd0, pix_rows[slot * FRAME_MAX + c - 2 * radius + dx][23:16],
                          24'd0, pix_rows[slot * FRAME_MAX + c - 2 * radius + dx][15:8],
                          24'd0, pix_rows[slot * FRAME_MAX + c - 2 * radius + dx][7:0]};
          lvl = ((pr + pg + pb) * gain) / 765;
          if (lvl > 255) lvl = 255;
          cnt[lvl]++;
          sr[lvl] += pr;
          sg[lvl] += pg;
          sb[lvl] += pb;
        end
      end
      best = 0;
      bestcnt = 0;
      for (int i = 0; i < 256; i++)
        if (cnt[i] > bestcnt) begin
          bestcnt = cnt[i];
          best = i;
        end
      if (bestcnt == 0) bestcnt = 1;
      o.out_col    = 10'(c - radius);
      o.out_row    = 10'(r - radius);
      o.red_out    = 8'(sr[best] / bestcnt);
      o.green_out  = 8'(sg[best] / bestcnt);
      o.blue_out   = 8'(sb[best] / bestcnt);
      o.frame_last = (c == w - 1 && r == h - 1);
      filtered_q.push_back(o);
    end
    next_col = c + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = r + 1;
      if (next_row >= h) next_row = 0;
    end
  endtask

  // Drive pixels and register writes from the pending list
  always @(posedge clk) begin
    logic push_n, cfgv_n;
    push_n = 1'b0;
    cfgv_n = 1'b0;
    if (rst_n) begin
      if (in_push && !in_full) begin
        filter_pixel(pending[0].pix);
        void'(pending.pop_front());
      end else if (cfg_valid && cfg_ready) begin
        case (pending[0].idx)
          CFG_WIDTH:  frame_w = pending[0].val;
          CFG_HEIGHT: frame_h = pending[0].val;
          CFG_RADIUS: radius  = pending[0].val[2:0];
          default:    gain    = pending[0].val[7:0];
        endcase
        void'(pending.pop_front());
      end
      if (pending.size() != 0) begin
        case (pending[0].kind)
          STEP_PIXEL: begin
            if (push_gap > 0) push_gap--;
            else if (!calm && $urandom_range(0, 11) == 0) push_gap = $urandom_range(0, 18);
            else push_n = 1'b1;
          end
          STEP_CONFIG: cfgv_n = 1'b1;
          default: begin
            if (filtered_q.size() == 0) begin
              settle_cnt++;
              if (settle_cnt >= SETTLE_CYCLES) begin
                settle_cnt = 0;
                void'(pending.pop_front());
              end
            end
          end
        endcase
      end
      in_push   <= push_n;
      cfg_valid <= cfgv_n;
      if (pending.size() != 0) begin
        in_data   <= pending[0].pix;
        cfg_index <= pending[0].idx;
        cfg_data  <= pending[0].val;
      end
    end
  end

  // Pop results with random stalls and compare against the oldest expectation
  always @(posedge clk) begin
    out_t e;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected item col=%0d row=%0d", out_data.out_col, out_data.out_row);
          errors++;
        end else begin
          e = filtered_q.pop_front();
          if (out_data.out_col !== e.out_col) begin
            $error("out_col exp %0d got %0d", e.out_col, out_data.out_col); errors++;
          end
          if (out_data.out_row !== e.out_row) begin
            $error("out_row exp %0d got %0d", e.out_row, out_data.out_row); errors++;
          end
          if (out_data.red_out !== e.red_out) begin
            $error("red_out exp %0d got %0d", e.red_out, out_data.red_out); errors++;
          end
          if (out_data.green_out !== e.green_out) begin
            $error("green_out exp %0d got %0d", e.green_out, out_data.green_out); errors++;
          end
          if (out_data.blue_out !== e.blue_out) begin
            $error("blue_out exp %0d got %0d", e.blue_out, out_data.blue_out); errors++;
          end
          if (out_data.frame_last !== e.frame_last) begin
            $error("frame_last exp %0d got %0d", e.frame_last, out_data.frame_last);
            errors++;
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        pop_gap = $urandom_range(0, 18);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic add_config(logic [1:0] idx, logic [10:0] val);
    step_t s;
    s.kind = STEP_CONFIG; s.idx = idx; s.val = val; s.pix = '0;
    pending.push_back(s);
  endtask

  task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    step_t s;
    s.kind = STEP_PIXEL; s.idx = CFG_WIDTH; s.val = '0; s.pix = {r, g, b};
    pending.push_back(s);
  endtask

  // Add one pixel of random color
  task automatic add_random_pixel();
    add_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  // Drain, then write all four registers for a new frame geometry
  task automatic add_setup(logic [10:0] w, logic [10:0] h, logic [10:0] rad, logic [10:0] g);
    step_t s;
    s.kind = STEP_SETTLE; s.idx = CFG_WIDTH; s.val = '0; s.pix = '0;
    pending.push_back(s);
    add_config(CFG_WIDTH, w);
    add_config(CFG_HEIGHT, h);
    add_config(CFG_RADIUS, rad);
    add_config(CFG_GAIN, g);
  endtask

  initial begin
    int w, h, rad, n, used;
    logic [23:0] palette[4];
    step_t s;

    // Directed frame: black/white tie with a single red, lowest level wins
    add_setup(11'd5, 11'd5, 11'd2, 11'd255);
    for (int i = 0; i < 25; i++)
      if (i == 0) add_pixel(8'd255, 8'd0, 8'd0);
      else if (i % 2 == 0) add_pixel(8'd0, 8'd0, 8'd0);
      else add_pixel(8'd255, 8'd255, 8'd255);

    // Width zero, radius zero, gain zero
    add_setup(11'd0, 11'd24, 11'd0, 11'd0);
    for (int i = 0; i < 24; i++) add_random_pixel();

    // Height zero
    add_setup(11'd16, 11'd0, 11'd0, 11'($urandom_range(0, 255)));
    for (int i = 0; i < 16; i++) add_random_pixel();

    // Largest radius
    add_setup(11'd15, 11'd15, 11'd7, 11'd40);
    for (int i = 0; i < 225; i++) add_random_pixel();

    // Random frames, mostly drawn from a small palette so bins collide
    used = 0;
    while (used < RANDOM_PIXELS) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      rad = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
      add_setup(11'(w), 11'(h), {8'($urandom), 3'(rad)}, {3'($urandom), 8'($urandom)});
      for (int k = 0; k < 4; k++) palette[k] = 24'($urandom);
      n = w * h;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          palette[0] = palette[$urandom_range(0, 3)];
          add_pixel(palette[0][23:16], palette[0][15:8], palette[0][7:0]);
        end else begin
          add_random_pixel();
        end
      end
      used += n;
    end
    s.kind = STEP_SETTLE; s.idx = CFG_WIDTH; s.val = '0; s.pix = '0;
    pending.push_back(s);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);

    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
    end else begin
      if (filtered_q.size() != 0) begin
        $error("%0d expected items never arrived", filtered_q.size());
        errors++;
      end
      if (errors == 0) begin
        $display("ALL CHECKS PASSED");
      end else begin
        $display("CHECKS FAILED");
      end
    end
    $finish;
  end

endmodule
